[src/lcdt_pkg.sv]
`timescale 1ns / 1ps

package lcdt_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_STAT = 2'd1;
	localparam logic [1:0] REG_LY   = 2'd2;
	localparam logic [1:0] REG_LYC  = 2'd3;

	localparam logic [9:0] DOTS_PER_LINE = 10'd456;
	localparam logic [8:0] TRANSFER_END  = 9'd252;
	localparam logic [8:0] OAM_END       = 9'd80;
	localparam logic [8:0] LCD_ON_DOT    = 9'd4;
	localparam logic [7:0] VBLANK_LINE   = 8'd144;
	localparam logic [7:0] LAST_LINE     = 8'd153;
	localparam logic [7:0] CTRL_RESET    = 8'h91;
	localparam int         LCD_ON_BIT    = 7;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE,
		OP_READ,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic [7:0] arg;
	} cmd_t;

	function automatic logic mode_irq(mode_t prev, mode_t nxt, logic [3:0] en);
		logic r;
		r = 1'b0;
		if (nxt != prev) begin
			unique case (nxt)
				MODE_HBLANK: r = en[0];
				MODE_VBLANK: r = en[1];
				MODE_OAM:    r = en[2];
				default:     r = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

[src/lcd_mode_timing_and_stat_irq_top.sv]
// LCD mode timing and STAT interrupt controller. Each input beat is a dot tick, a
// register write, a register read or a no-op (unused action), and gives exactly one
// result beat carrying the read byte, the interrupt requests raised by that beat, the
// mode, the line and the OAM lock. One beat is taken every clock cycle while the
// queue has room; its result goes through the queue, then the output register. The
// front part decodes beats into a two-entry queue, so input is taken while a result
// waits under stall; the rate is set by the back part, which applies one beat per
// cycle unless stalled (one dot add, one line-length compare and at most one line wrap).
`timescale 1ns / 1ps

module lcd_mode_timing_and_stat_irq_top
	import lcdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [1:0] reg_index,
	input  logic [7:0] write_data,
	input  logic [7:0] tick_cycles,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       vblank_irq,
	output logic       stat_irq,
	output logic [1:0] ppu_mode,
	output logic [7:0] current_line,
	output logic       oam_locked
);

	cmd_t dec_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_valid;

	lcdt_front u_front (
		.in_valid    (in_valid),
		.action      (action),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.tick_cycles (tick_cycles),
		.queue_full  (queue_full),
		.in_stall    (in_stall),
		.push        (push),
		.cmd         (dec_cmd)
	);

	lcdt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (dec_cmd),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_valid),
		.head      (head_cmd)
	);

	lcdt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (queue_valid),
		.cmd          (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.vblank_irq   (vblank_irq),
		.stat_irq     (stat_irq),
		.ppu_mode     (ppu_mode),
		.current_line (current_line),
		.oam_locked   (oam_locked)
	);

endmodule

[src/lcdt_front.sv]
`timescale 1ns / 1ps

module lcdt_front
	import lcdt_pkg::*;
(
	input  logic       in_valid,
	input  logic [1:0] action,
	input  logic [1:0] reg_index,
	input  logic [7:0] write_data,
	input  logic [7:0] tick_cycles,
	input  logic       queue_full,
	output logic       in_stall,
	output logic       push,
	output cmd_t       cmd
);

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		cmd.idx = reg_index;
		unique case (action)
			ACT_TICK: begin
				cmd.op  = OP_TICK;
				cmd.arg = tick_cycles;
			end
			ACT_WRITE: begin
				cmd.op  = OP_WRITE;
				cmd.arg = write_data;
			end
			ACT_READ: begin
				cmd.op  = OP_READ;
				cmd.arg = write_data;
			end
			default: begin
				cmd.op  = OP_NOP;
				cmd.arg = write_data;
			end
		endcase
	end

endmodule

[src/lcdt_fifo.sv]
`timescale 1ns / 1ps

module lcdt_fifo
	import lcdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/lcdt_back.sv]
`timescale 1ns / 1ps

module lcdt_back
	import lcdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       vblank_irq,
	output logic       stat_irq,
	output logic [1:0] ppu_mode,
	output logic [7:0] current_line,
	output logic       oam_locked
);

	logic [7:0] ctrl_q;
	logic [3:0] en_q;
	logic       flag_q;
	mode_t      mode_q;
	logic [7:0] line_q;
	logic [7:0] cmp_q;
	logic [8:0] dot_q;
	logic       out_valid_q;

	logic [7:0] n_ctrl;
	logic [3:0] n_en;
	logic       n_flag;
	mode_t      n_mode;
	logic [7:0] n_line;
	logic [7:0] n_cmp;
	logic [8:0] n_dot;
	logic [7:0] n_rd;
	logic       n_vb;
	logic       n_stat;

	assign pop       = cmd_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		logic [9:0] sum;
		logic [9:0] dw;
		logic [7:0] line_inc;
		mode_t      mode_a;
		logic       match;

		n_ctrl   = ctrl_q;
		n_en     = en_q;
		n_flag   = flag_q;
		n_mode   = mode_q;
		n_line   = line_q;
		n_cmp    = cmp_q;
		n_dot    = dot_q;
		n_rd     = '0;
		n_vb     = 1'b0;
		n_stat   = 1'b0;
		sum      = {1'b0, dot_q} + {2'b00, cmd.arg};
		dw       = sum;
		line_inc = line_q + 8'd1;
		mode_a   = mode_q;
		match    = 1'b0;

		case (cmd.op)
			OP_TICK: begin
				if (ctrl_q[LCD_ON_BIT]) begin
					if (sum >= DOTS_PER_LINE) begin
						dw = sum - DOTS_PER_LINE;
						if (line_inc == VBLANK_LINE) begin
							n_line = line_inc;
							mode_a = MODE_VBLANK;
							n_vb   = 1'b1;
						end else if (line_inc > LAST_LINE) begin
							n_line = '0;
							mode_a = MODE_OAM;
						end else begin
							n_line = line_inc;
						end
						match  = (n_line == cmp_q);
						n_flag = match;
						n_stat = mode_irq(mode_q, mode_a, en_q) ||
							(match && !flag_q && en_q[3]);
					end
					n_dot = dw[8:0];
					if (n_line >= VBLANK_LINE) begin
						n_mode = MODE_VBLANK;
					end else if (n_dot < OAM_END) begin
						n_mode = MODE_OAM;
					end else if (n_dot < TRANSFER_END) begin
						n_mode = MODE_XFER;
					end else begin
						n_mode = MODE_HBLANK;
					end
					n_stat = n_stat || mode_irq(mode_a, n_mode, en_q);
				end
			end
			OP_WRITE: begin
				unique case (cmd.idx)
					REG_CTRL: begin
						n_ctrl = cmd.arg;
						if (!cmd.arg[LCD_ON_BIT]) begin
							n_dot  = '0;
							n_line = '0;
							n_mode = MODE_HBLANK;
						end else if (!ctrl_q[LCD_ON_BIT]) begin
							n_dot  = LCD_ON_DOT;
							n_line = '0;
							n_mode = MODE_OAM;
						end
					end
					REG_STAT: n_en = cmd.arg[6:3];
					REG_LY: begin
						n_line = '0;
						n_dot  = '0;
					end
					default: n_cmp = cmd.arg;
				endcase
				match  = (n_line == n_cmp);
				n_flag = match;
				n_stat = mode_irq(mode_q, n_mode, en_q) || (match && !flag_q && n_en[3]);
			end
			OP_READ: begin
				unique case (cmd.idx)
					REG_CTRL: n_rd = ctrl_q;
					REG_STAT: n_rd = {1'b1, en_q, flag_q, mode_q};
					REG_LY:   n_rd = line_q;
					default:  n_rd = cmp_q;
				endcase
			end
			default: begin
				n_rd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= CTRL_RESET;
			en_q        <= '0;
			flag_q      <= 1'b1;
			mode_q      <= MODE_OAM;
			line_q      <= '0;
			cmp_q       <= '0;
			dot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ctrl_q <= n_ctrl;
				en_q   <= n_en;
				flag_q <= n_flag;
				mode_q <= n_mode;
				line_q <= n_line;
				cmp_q  <= n_cmp;
				dot_q  <= n_dot;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			read_data    <= n_rd;
			vblank_irq   <= n_vb;
			stat_irq     <= n_stat;
			ppu_mode     <= n_mode;
			current_line <= n_line;
			oam_locked   <= n_ctrl[LCD_ON_BIT] && (n_line < VBLANK_LINE) && (n_dot < OAM_END);
		end
	end

endmodule

[src/lcdt_checker.sv]
`timescale 1ns / 1ps

module lcdt_checker
	import lcdt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       vblank_irq,
	input logic       stat_irq,
	input logic [1:0] ppu_mode,
	input logic [7:0] current_line,
	input logic       oam_locked
);

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_line <= LAST_LINE)
		else $error("line counter beyond last line");

	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vblank_irq |-> current_line == VBLANK_LINE &&
			ppu_mode == MODE_VBLANK && !oam_locked)
		else $error("vblank request outside vblank entry");

	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && current_line >= VBLANK_LINE |-> ppu_mode == MODE_VBLANK)
		else $error("mode not vblank on a vblank line");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) &&
			$stable(stat_irq) && $stable(current_line) && $stable(ppu_mode))
		else $error("stalled result beat changed");

endmodule

bind lcd_mode_timing_and_stat_irq_top lcdt_checker u_lcdt_checker (.*);

[tb/tb_lcd_mode_timing_and_stat_irq_top.sv]
`timescale 1ns / 1ps

module tb_lcd_mode_timing_and_stat_irq_top
	import lcdt_pkg::*;
();

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [7:0] read_data;
		logic       vblank_irq;
		logic       stat_irq;
		logic [1:0] ppu_mode;
		logic [7:0] current_line;
		logic       oam_locked;
	} lcd_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = ACT_TICK;
	logic [1:0] reg_index = REG_CTRL;
	logic [7:0] write_data = 8'h00;
	logic [7:0] tick_cycles = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic       vblank_irq;
	logic       stat_irq;
	logic [1:0] ppu_mode;
	logic [7:0] current_line;
	logic       oam_locked;

	lcd_result_t expected_results[$];
	lcd_result_t want;
	int errors = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;

	logic [7:0] ctrl_m;
	logic [3:0] enables_m;
	logic       coinc_m;
	mode_t      mode_m;
	logic [7:0] line_m;
	logic [7:0] lyc_m;
	logic [8:0] dot_m;
	logic       stat_hit;
	logic       vblank_hit;

	lcd_mode_timing_and_stat_irq_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.reg_index(reg_index),
		.write_data(write_data),
		.tick_cycles(tick_cycles),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.ppu_mode(ppu_mode),
		.current_line(current_line),
		.oam_locked(oam_locked)
	);

	always #5 clk = ~clk;

	function automatic void set_mode(mode_t m);
		if (m != mode_m) begin
			case (m)
				MODE_HBLANK: if (enables_m[0]) stat_hit = 1'b1;
				MODE_VBLANK: if (enables_m[1]) stat_hit = 1'b1;
				MODE_OAM: if (enables_m[2]) stat_hit = 1'b1;
				default: ;
			endcase
		end
		mode_m = m;
	endfunction

	function automatic void update_match();
		logic hit;
		hit = (line_m == lyc_m);
		if (hit && !coinc_m && enables_m[3])
			stat_hit = 1'b1;
		coinc_m = hit;
	endfunction

	function automatic lcd_result_t predict_lcd_result(logic [1:0] act, logic [1:0] idx,
			logic [7:0] data, logic [7:0] dots);
		lcd_result_t r;
		logic [9:0] sum;
		r.read_data = 8'h00;
		stat_hit = 1'b0;
		vblank_hit = 1'b0;
		case (act)
			ACT_TICK: begin
				if (ctrl_m[LCD_ON_BIT]) begin
					sum = {1'b0, dot_m} + {2'b00, dots};
					if (sum >= DOTS_PER_LINE) begin
						sum = sum - DOTS_PER_LINE;
						line_m = line_m + 8'd1;
						if (line_m == VBLANK_LINE) begin
							set_mode(MODE_VBLANK);
							vblank_hit = 1'b1;
						end else if (line_m > LAST_LINE) begin
							line_m = 8'd0;
							set_mode(MODE_OAM);
						end
						update_match();
					end
					if (sum >= DOTS_PER_LINE)
						sum = DOTS_PER_LINE - 10'd1;
					dot_m = sum[8:0];
					if (line_m >= VBLANK_LINE)
						set_mode(MODE_VBLANK);
					else if (dot_m < OAM_END)
						set_mode(MODE_OAM);
					else if (dot_m < TRANSFER_END)
						set_mode(MODE_XFER);
					else
						set_mode(MODE_HBLANK);
				end
			end
			ACT_WRITE: begin
				case (idx)
					REG_CTRL: begin
						if (!data[LCD_ON_BIT]) begin
							dot_m = 9'd0;
							line_m = 8'd0;
							set_mode(MODE_HBLANK);
						end else if (!ctrl_m[LCD_ON_BIT]) begin
							dot_m = LCD_ON_DOT;
							line_m = 8'd0;
							set_mode(MODE_OAM);
						end
						ctrl_m = data;
					end
					REG_STAT: enables_m = data[6:3];
					REG_LY: begin
						line_m = 8'd0;
						dot_m = 9'd0;
					end
					default: lyc_m = data;
				endcase
				update_match();
			end
			ACT_READ: begin
				case (idx)
					REG_CTRL: r.read_data = ctrl_m;
					REG_STAT: r.read_data = {1'b1, enables_m, coinc_m, mode_m};
					REG_LY: r.read_data = line_m;
					default: r.read_data = lyc_m;
				endcase
			end
			default: ;
		endcase
		r.vblank_irq = vblank_hit;
		r.stat_irq = stat_hit;
		r.ppu_mode = mode_m;
		r.current_line = line_m;
		r.oam_locked = ctrl_m[LCD_ON_BIT] && (line_m < VBLANK_LINE) && (dot_m < OAM_END);
		return r;
	endfunction

	function automatic void check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none, actual line %h",
					$time, current_line);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_data", want.read_data, read_data);
				check_field("vblank_irq", 8'(want.vblank_irq), 8'(vblank_irq));
				check_field("stat_irq", 8'(want.stat_irq), 8'(stat_irq));
				check_field("ppu_mode", 8'(want.ppu_mode), 8'(ppu_mode));
				check_field("current_line", want.current_line, current_line);
				check_field("oam_locked", 8'(want.oam_locked), 8'(oam_locked));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 37);
		end
	end

	task automatic send_beat(logic [1:0] act, logic [1:0] idx, logic [7:0] data,
			logic [7:0] dots);
		while (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		reg_index <= idx;
		write_data <= data;
		tick_cycles <= dots;
		do @(posedge clk); while (in_stall);
		expected_results.insert(expected_results.size(),
			predict_lcd_result(act, idx, data, dots));
	endtask

	// clean beats keep the LCD on and the line running; noisy ones may also turn it off or reset the line
	task automatic send_frame_beat(bit noisy);
		int pick;
		logic [7:0] data;
		logic [7:0] dots;
		logic [1:0] idx;
		pick = $urandom_range(999);
		data = 8'($urandom);
		dots = 8'($urandom);
		idx = 2'($urandom_range(3));
		if (!ctrl_m[LCD_ON_BIT] && pick < 500)
			send_beat(ACT_WRITE, REG_CTRL, data | 8'h80, dots);
		else if (pick < 800)
			send_beat(ACT_TICK, idx, data, dots);
		else if (pick < 880)
			send_beat(ACT_READ, idx, data, dots);
		else if (pick < 920)
			send_beat(ACT_WRITE, REG_LYC, pick[0] ? data : 8'($urandom_range(153)), dots);
		else if (pick < 950)
			send_beat(ACT_WRITE, REG_STAT, data, dots);
		else if (pick < 970)
			send_beat(ACT_WRITE, REG_CTRL, noisy ? data : (data | 8'h80), dots);
		else if (pick < 985 && noisy)
			send_beat(ACT_WRITE, REG_LY, data, dots);
		else if (pick < 990)
			send_beat(ACT_UNUSED, idx, data, dots);
		else
			send_beat(ACT_TICK, idx, data, 8'hFF);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_beat(ACT_READ, REG_CTRL, 8'h00, 8'h00);
		send_beat(ACT_READ, REG_STAT, 8'hFF, 8'hFF);
		send_beat(ACT_READ, REG_LY, 8'h00, 8'h00);
		send_beat(ACT_READ, REG_LYC, 8'hFF, 8'hFF);
		send_beat(ACT_UNUSED, REG_LYC, 8'hFF, 8'hFF);
		send_beat(ACT_TICK, REG_CTRL, 8'h00, 8'h00);
	endtask

	task automatic test_lcd_switching();
		send_beat(ACT_WRITE, REG_STAT, 8'hFF, 8'h00);
		send_beat(ACT_WRITE, REG_CTRL, 8'h00, 8'h00);
		send_beat(ACT_TICK, REG_CTRL, 8'h00, 8'hFF);
		send_beat(ACT_READ, REG_STAT, 8'h00, 8'h00);
		send_beat(ACT_WRITE, REG_LY, 8'hFF, 8'h00);
		send_beat(ACT_WRITE, REG_CTRL, 8'hFF, 8'h00);
		send_beat(ACT_WRITE, REG_LYC, 8'h01, 8'h00);
		send_beat(ACT_TICK, REG_CTRL, 8'h00, 8'hFF);
		send_beat(ACT_TICK, REG_CTRL, 8'h00, 8'hFF);
		send_beat(ACT_READ, REG_LY, 8'h00, 8'h00);
		send_beat(ACT_WRITE, REG_LY, 8'h00, 8'h00);
		send_beat(ACT_WRITE, REG_STAT, 8'h87, 8'h00);
		send_beat(ACT_TICK, REG_CTRL, 8'h00, 8'h00);
		send_beat(ACT_WRITE, REG_LYC, 8'hFF, 8'h00);
		send_beat(ACT_READ, REG_LYC, 8'h00, 8'h00);
		send_beat(ACT_WRITE, REG_CTRL, CTRL_RESET, 8'h00);
		send_beat(ACT_READ, REG_CTRL, 8'h00, 8'h00);
	endtask

	task automatic test_frames();
		send_beat(ACT_WRITE, REG_STAT, 8'($urandom), 8'h00);
		repeat (1100) send_frame_beat(1'b0);
	endtask

	task automatic test_noise();
		repeat (250) send_frame_beat(1'b1);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (60) send_frame_beat(1'b0);
	endtask

	task automatic test_pause_drain();
		drain_results();
		repeat (20) send_frame_beat(1'b0);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		repeat (300) send_frame_beat(1'b0);
		idle_on = 1'b1;
	endtask

	initial begin
		ctrl_m = CTRL_RESET;
		enables_m = 4'd0;
		coinc_m = 1'b1;
		mode_m = MODE_OAM;
		line_m = 8'd0;
		lyc_m = 8'd0;
		dot_m = 9'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_lcd_switching();
		test_frames();
		test_noise();
		test_backpressure();
		test_pause_drain();
		test_no_idle();
		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
src/lcdt_pkg.sv
src/lcdt_front.sv
src/lcdt_fifo.sv
src/lcdt_back.sv
src/lcd_mode_timing_and_stat_irq_top.sv
src/lcdt_checker.sv
tb/tb_lcd_mode_timing_and_stat_irq_top.sv
